// ===== src/cbcr_pkg.sv =====
// Package for the circle versus box collision response block.
// Holds the shared field widths, the carry record type and the saturation helper.
// No dependencies.
package cbcr_pkg;

  localparam int unsigned CoordW      = 24;
  localparam int unsigned RadW        = 16;
  localparam int unsigned DistW       = 16;
  localparam int unsigned RadSqW      = 32;
  localparam int unsigned NormFracDef = 14;

  typedef logic signed [CoordW-1:0] coord_t;

  // Fields that ride along the pipeline with each transaction.
  typedef struct packed {
    logic   hit;
    logic   sx;
    logic   sy;
    coord_t px;
    coord_t py;
    coord_t vx;
    coord_t vy;
  } carry_t;

  // Saturate a wide signed value to the signed coordinate range.
  function automatic coord_t sat_coord(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = 64'sd8388607;
      lo = -64'sd8388608;
      if (v > hi) begin
        return coord_t'(hi);
      end else if (v < lo) begin
        return coord_t'(lo);
      end
      return coord_t'(v);
    end
  endfunction

endpackage

// ===== src/circle_box_collision_resolve.sv =====
// Circle versus axis-aligned box collision response, fully pipelined.
// Depends on cbcr_pkg.
//
// Usage: the input channel (in_valid_i / in_ready_o) carries one transaction
// per collision pair: the box edges, the circle center and radius, and the
// object position and velocity. The output channel (out_valid_o /
// out_ready_i) returns one transaction per input: the hit flag and the
// corrected position and velocity.
// Throughput is one transaction per cycle while the receiver does not stall.
// The pipeline has 26 + NORMAL_FRAC_BITS register stages (40 by default),
// set by the 16-stage square root and the one-bit-per-stage normal dividers.
// Reset clears every stage valid bit; payload registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated, and the pipeline
// moves again in the cycle that out_ready_i returns.
module circle_box_collision_resolve #(
  parameter int unsigned NORMAL_FRAC_BITS = cbcr_pkg::NormFracDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [cbcr_pkg::CoordW-1:0] box_left_i,
  input  logic signed [cbcr_pkg::CoordW-1:0] box_top_i,
  input  logic signed [cbcr_pkg::CoordW-1:0] box_right_i,
  input  logic signed [cbcr_pkg::CoordW-1:0] box_bottom_i,
  input  logic signed [cbcr_pkg::CoordW-1:0] center_x_i,
  input  logic signed [cbcr_pkg::CoordW-1:0] center_y_i,
  input  logic [cbcr_pkg::RadW-1:0]      circle_radius_i,
  input  logic signed [cbcr_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [cbcr_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [cbcr_pkg::CoordW-1:0] vel_x_i,
  input  logic signed [cbcr_pkg::CoordW-1:0] vel_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic signed [cbcr_pkg::CoordW-1:0] new_pos_x_o,
  output logic signed [cbcr_pkg::CoordW-1:0] new_pos_y_o,
  output logic signed [cbcr_pkg::CoordW-1:0] new_vel_x_o,
  output logic signed [cbcr_pkg::CoordW-1:0] new_vel_y_o
);

  localparam int unsigned CW  = cbcr_pkg::CoordW;
  localparam int unsigned RW  = cbcr_pkg::RadW;
  localparam int unsigned DW  = cbcr_pkg::DistW;
  localparam int unsigned NF  = NORMAL_FRAC_BITS;
  localparam int unsigned QW  = NF + 1;
  localparam int unsigned NXW = NF + 2;
  localparam int unsigned NW  = DW + NF + 1;
  localparam int unsigned DQW = CW + 2;
  localparam int unsigned PW  = NXW + RW + 1;
  localparam int unsigned VW  = CW + NXW;
  localparam int unsigned QPW = DQW + NXW;
  localparam int unsigned SQN = DW;

  // Round v / 2^NF to nearest, half away from zero.
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] res;
    begin
      mag = v[63] ? 64'(-v) : 64'(v);
      res = (mag + (64'd1 << (NF - 1))) >> NF;
      return v[63] ? -$signed(res) : $signed(res);
    end
  endfunction

  // Closest point coordinate of the box for one axis.
  function automatic cbcr_pkg::coord_t clamp_edge(input cbcr_pkg::coord_t c,
                                                  input cbcr_pkg::coord_t lo,
                                                  input cbcr_pkg::coord_t hi);
    cbcr_pkg::coord_t t;
    begin
      t = (c < hi) ? c : hi;
      return (lo > t) ? lo : t;
    end
  endfunction

  logic en;
  logic out_valid_q;

  // The whole pipeline advances unless a finished result is stalled.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: clamp the center into the box and form the offsets.
  logic                 s1_v_q;
  logic signed [CW:0]   s1_dx_q, s1_dy_q;
  logic [RW-1:0]        s1_r_q;
  cbcr_pkg::carry_t     s1_c_q;
  cbcr_pkg::coord_t     cl_x, cl_y;

  always_comb begin
    cl_x = clamp_edge(center_x_i, box_left_i, box_right_i);
    cl_y = clamp_edge(center_y_i, box_top_i, box_bottom_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q    <= (CW+1)'(center_x_i) - (CW+1)'(cl_x);
      s1_dy_q    <= (CW+1)'(center_y_i) - (CW+1)'(cl_y);
      s1_r_q     <= circle_radius_i;
      s1_c_q.hit <= 1'b0;
      s1_c_q.sx  <= 1'b0;
      s1_c_q.sy  <= 1'b0;
      s1_c_q.px  <= pos_x_i;
      s1_c_q.py  <= pos_y_i;
      s1_c_q.vx  <= vel_x_i;
      s1_c_q.vy  <= vel_y_i;
    end
  end

  // Stage 2: squares of the offsets and of the radius.
  logic                    s2_v_q;
  logic [2*CW+1:0]         s2_dx2_q, s2_dy2_q;
  logic [cbcr_pkg::RadSqW-1:0] s2_r2_q;
  logic signed [CW:0]      s2_dx_q, s2_dy_q;
  logic [RW-1:0]           s2_r_q;
  cbcr_pkg::carry_t        s2_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_dx2_q <= (2*CW+2)'(s1_dx_q * s1_dx_q);
      s2_dy2_q <= (2*CW+2)'(s1_dy_q * s1_dy_q);
      s2_r2_q  <= {{RW{1'b0}}, s1_r_q} * {{RW{1'b0}}, s1_r_q};
      s2_dx_q  <= s1_dx_q;
      s2_dy_q  <= s1_dy_q;
      s2_r_q   <= s1_r_q;
      s2_c_q   <= s1_c_q;
    end
  end

  // Stage 3: overlap test; on a miss the radicand and offsets are zeroed.
  logic                    s3_v_q;
  logic [cbcr_pkg::RadSqW-1:0] s3_rad_q;
  logic [DW-1:0]           s3_ax_q, s3_ay_q;
  logic [RW-1:0]           s3_r_q;
  cbcr_pkg::carry_t        s3_c_q;
  logic [2*CW+2:0]         d2;
  logic                    s3_hit;
  logic [CW:0]             adx, ady;

  always_comb begin
    d2     = (2*CW+3)'(s2_dx2_q) + (2*CW+3)'(s2_dy2_q);
    s3_hit = d2 < (2*CW+3)'(s2_r2_q);
    adx    = s2_dx_q[CW] ? (CW+1)'(-s2_dx_q) : (CW+1)'(s2_dx_q);
    ady    = s2_dy_q[CW] ? (CW+1)'(-s2_dy_q) : (CW+1)'(s2_dy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rad_q <= s3_hit ? d2[cbcr_pkg::RadSqW-1:0] : '0;
      s3_ax_q  <= s3_hit ? adx[DW-1:0] : '0;
      s3_ay_q  <= s3_hit ? ady[DW-1:0] : '0;
      s3_r_q   <= s2_r_q;
      s3_c_q   <= '{hit: s3_hit, sx: s2_dx_q[CW], sy: s2_dy_q[CW],
                    px: s2_c_q.px, py: s2_c_q.py, vx: s2_c_q.vx, vy: s2_c_q.vy};
    end
  end

  // Square root, one result bit per stage.
  logic                    sq_v_q   [1:SQN];
  logic [cbcr_pkg::RadSqW-1:0] sq_rad_q [1:SQN];
  logic [DW+1:0]           sq_rem_q [1:SQN];
  logic [DW-1:0]           sq_root_q[1:SQN];
  logic [DW-1:0]           sq_ax_q  [1:SQN];
  logic [DW-1:0]           sq_ay_q  [1:SQN];
  logic [RW-1:0]           sq_r_q   [1:SQN];
  cbcr_pkg::carry_t        sq_c_q   [1:SQN];

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    logic                    v_in;
    logic [cbcr_pkg::RadSqW-1:0] rad_in;
    logic [DW+1:0]           rem_in;
    logic [DW-1:0]           root_in;
    logic [DW-1:0]           ax_in, ay_in;
    logic [RW-1:0]           r_in;
    cbcr_pkg::carry_t        c_in;
    logic [DW+3:0]           rem_n;
    logic [DW+3:0]           trial;

    if (k == 0) begin : g_first
      assign v_in    = s3_v_q;
      assign rad_in  = s3_rad_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign ax_in   = s3_ax_q;
      assign ay_in   = s3_ay_q;
      assign r_in    = s3_r_q;
      assign c_in    = s3_c_q;
    end else begin : g_rest
      assign v_in    = sq_v_q[k];
      assign rad_in  = sq_rad_q[k];
      assign rem_in  = sq_rem_q[k];
      assign root_in = sq_root_q[k];
      assign ax_in   = sq_ax_q[k];
      assign ay_in   = sq_ay_q[k];
      assign r_in    = sq_r_q[k];
      assign c_in    = sq_c_q[k];
    end

    // Bring down the next pair of radicand bits and try the next root bit.
    assign rem_n = {rem_in, rad_in[cbcr_pkg::RadSqW-1-2*k -: 2]};
    assign trial = rem_n - {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rad_q[k+1]  <= rad_in;
        sq_rem_q[k+1]  <= trial[DW+3] ? rem_n[DW+1:0] : trial[DW+1:0];
        sq_root_q[k+1] <= {root_in[DW-2:0], ~trial[DW+3]};
        sq_ax_q[k+1]   <= ax_in;
        sq_ay_q[k+1]   <= ay_in;
        sq_r_q[k+1]    <= r_in;
        sq_c_q[k+1]    <= c_in;
      end
    end
  end

  // Overlap and rounded normal numerators.
  logic               pp_v_q;
  logic [DW-1:0]      pp_d_q;
  logic [RW-1:0]      pp_ovl_q;
  logic               pp_dz_q;
  logic [NW-1:0]      pp_nx_q, pp_ny_q;
  cbcr_pkg::carry_t   pp_c_q;
  logic [DW-1:0]      sq_d;

  assign sq_d = sq_root_q[SQN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q <= 1'b0;
    end else if (en) begin
      pp_v_q <= sq_v_q[SQN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_d_q   <= sq_d;
      pp_ovl_q <= sq_r_q[SQN] - sq_d;
      pp_dz_q  <= (sq_d == '0);
      pp_nx_q  <= {1'b0, sq_ax_q[SQN], {NF{1'b0}}} + NW'(sq_d >> 1);
      pp_ny_q  <= {1'b0, sq_ay_q[SQN], {NF{1'b0}}} + NW'(sq_d >> 1);
      pp_c_q   <= sq_c_q[SQN];
    end
  end

  // Normal dividers, one quotient bit per stage, both axes side by side.
  logic               dv_v_q  [1:QW];
  logic [DW-1:0]      dv_d_q  [1:QW];
  logic [RW-1:0]      dv_ovl_q[1:QW];
  logic               dv_dz_q [1:QW];
  logic [NW-1:0]      dv_rx_q [1:QW];
  logic [NW-1:0]      dv_ry_q [1:QW];
  logic [QW-1:0]      dv_qx_q [1:QW];
  logic [QW-1:0]      dv_qy_q [1:QW];
  cbcr_pkg::carry_t   dv_c_q  [1:QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic             v_in;
    logic [DW-1:0]    d_in;
    logic [RW-1:0]    ovl_in;
    logic             dz_in;
    logic [NW-1:0]    rx_in, ry_in;
    logic [QW-1:0]    qx_in, qy_in;
    cbcr_pkg::carry_t c_in;
    logic [NW-1:0]    dsh;
    logic             gx, gy;

    if (j == 0) begin : g_first
      assign v_in   = pp_v_q;
      assign d_in   = pp_d_q;
      assign ovl_in = pp_ovl_q;
      assign dz_in  = pp_dz_q;
      assign rx_in  = pp_nx_q;
      assign ry_in  = pp_ny_q;
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign c_in   = pp_c_q;
    end else begin : g_rest
      assign v_in   = dv_v_q[j];
      assign d_in   = dv_d_q[j];
      assign ovl_in = dv_ovl_q[j];
      assign dz_in  = dv_dz_q[j];
      assign rx_in  = dv_rx_q[j];
      assign ry_in  = dv_ry_q[j];
      assign qx_in  = dv_qx_q[j];
      assign qy_in  = dv_qy_q[j];
      assign c_in   = dv_c_q[j];
    end

    // Compare the partial remainder against the shifted divisor.
    assign dsh = NW'(d_in) << (QW - 1 - j);
    assign gx  = rx_in >= dsh;
    assign gy  = ry_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_d_q[j+1]   <= d_in;
        dv_ovl_q[j+1] <= ovl_in;
        dv_dz_q[j+1]  <= dz_in;
        dv_rx_q[j+1]  <= gx ? rx_in - dsh : rx_in;
        dv_ry_q[j+1]  <= gy ? ry_in - dsh : ry_in;
        dv_qx_q[j+1]  <= QW'({qx_in, gx});
        dv_qy_q[j+1]  <= QW'({qy_in, gy});
        dv_c_q[j+1]   <= c_in;
      end
    end
  end

  // Signed normal; a center on the closest point takes the upward normal.
  logic                nn_v_q;
  logic signed [NXW-1:0] nn_nx_q, nn_ny_q;
  logic [RW-1:0]       nn_ovl_q;
  cbcr_pkg::carry_t    nn_c_q;
  logic signed [NXW-1:0] mx, my;

  always_comb begin
    mx = $signed(NXW'(dv_qx_q[QW]));
    my = $signed(NXW'(dv_qy_q[QW]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nn_v_q <= 1'b0;
    end else if (en) begin
      nn_v_q <= dv_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_dz_q[QW]) begin
        nn_nx_q <= '0;
        nn_ny_q <= -($signed(NXW'(1)) <<< NF);
      end else begin
        nn_nx_q <= dv_c_q[QW].sx ? -mx : mx;
        nn_ny_q <= dv_c_q[QW].sy ? -my : my;
      end
      nn_ovl_q <= dv_ovl_q[QW];
      nn_c_q   <= dv_c_q[QW];
    end
  end

  // Products of the normal with the overlap and with the velocity.
  logic                m1_v_q;
  logic signed [PW-1:0] m1_px_q, m1_py_q;
  logic signed [VW-1:0] m1_vx_q, m1_vy_q;
  logic signed [NXW-1:0] m1_nx_q, m1_ny_q;
  cbcr_pkg::carry_t    m1_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= nn_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_px_q <= PW'(nn_nx_q * $signed({1'b0, nn_ovl_q}));
      m1_py_q <= PW'(nn_ny_q * $signed({1'b0, nn_ovl_q}));
      m1_vx_q <= VW'(nn_c_q.vx * nn_nx_q);
      m1_vy_q <= VW'(nn_c_q.vy * nn_ny_q);
      m1_nx_q <= nn_nx_q;
      m1_ny_q <= nn_ny_q;
      m1_c_q  <= nn_c_q;
    end
  end

  // Corrected position and the rounded normal velocity.
  logic                m2_v_q;
  logic signed [DQW-1:0] m2_dq_q;
  cbcr_pkg::coord_t    m2_px_q, m2_py_q;
  logic signed [NXW-1:0] m2_nx_q, m2_ny_q;
  cbcr_pkg::carry_t    m2_c_q;
  logic signed [63:0]  dq_w;

  assign dq_w = rnd_sh(64'(m1_vx_q) + 64'(m1_vy_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_dq_q <= dq_w[DQW-1:0];
      if (m1_c_q.hit) begin
        m2_px_q <= cbcr_pkg::sat_coord(64'(m1_c_q.px) + rnd_sh(64'(m1_px_q)));
        m2_py_q <= cbcr_pkg::sat_coord(64'(m1_c_q.py) + rnd_sh(64'(m1_py_q)));
      end else begin
        m2_px_q <= m1_c_q.px;
        m2_py_q <= m1_c_q.py;
      end
      m2_nx_q <= m1_nx_q;
      m2_ny_q <= m1_ny_q;
      m2_c_q  <= m1_c_q;
    end
  end

  // Normal velocity projected back onto the normal.
  logic                m3_v_q;
  logic signed [QPW-1:0] m3_qx_q, m3_qy_q;
  cbcr_pkg::coord_t    m3_px_q, m3_py_q;
  cbcr_pkg::carry_t    m3_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
    end else if (en) begin
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_qx_q <= QPW'(m2_dq_q * m2_nx_q);
      m3_qy_q <= QPW'(m2_dq_q * m2_ny_q);
      m3_px_q <= m2_px_q;
      m3_py_q <= m2_py_q;
      m3_c_q  <= m2_c_q;
    end
  end

  // Output register: sliding velocity and the final transaction.
  logic             hit_q;
  cbcr_pkg::coord_t npx_q, npy_q, nvx_q, nvy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= m3_c_q.hit;
      npx_q <= m3_px_q;
      npy_q <= m3_py_q;
      if (m3_c_q.hit) begin
        nvx_q <= cbcr_pkg::sat_coord(64'(m3_c_q.vx) - rnd_sh(64'(m3_qx_q)));
        nvy_q <= cbcr_pkg::sat_coord(64'(m3_c_q.vy) - rnd_sh(64'(m3_qy_q)));
      end else begin
        nvx_q <= m3_c_q.vx;
        nvy_q <= m3_c_q.vy;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign new_pos_x_o = npx_q;
  assign new_pos_y_o = npy_q;
  assign new_vel_x_o = nvx_q;
  assign new_vel_y_o = nvy_q;

endmodule

// ===== src/cbcr_checker.sv =====
// Port-level checker for the collision response block, with its bind.
// Depends on cbcr_pkg and circle_box_collision_resolve.
module cbcr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           hit_o,
  input logic signed [cbcr_pkg::CoordW-1:0] new_pos_x_o,
  input logic signed [cbcr_pkg::CoordW-1:0] new_pos_y_o,
  input logic signed [cbcr_pkg::CoordW-1:0] new_vel_x_o,
  input logic signed [cbcr_pkg::CoordW-1:0] new_vel_y_o
);

  // A stalled result transaction holds its valid and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
      $stable(new_pos_x_o) && $stable(new_pos_y_o) &&
      $stable(new_vel_x_o) && $stable(new_vel_y_o))
    else $error("stalled result changed");

  // The input side is open exactly when the output stage can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  // Reset leaves the pipeline empty when it is released.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind circle_box_collision_resolve cbcr_checker u_cbcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hit_o       (hit_o),
  .new_pos_x_o (new_pos_x_o),
  .new_pos_y_o (new_pos_y_o),
  .new_vel_x_o (new_vel_x_o),
  .new_vel_y_o (new_vel_y_o)
);

// ===== test/circle_box_collision_resolve_tb.sv =====
// Testbench for the circle versus box collision response block. Depends on
// cbcr_pkg and the block's RTL. Drives a directed table and random collision
// pairs; checks each result against a known response or behavioral predictor.
module circle_box_collision_resolve_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NormFrac = cbcr_pkg::NormFracDef;
  localparam int Latency = 26 + NormFrac;
  localparam int RandomPairs = 1630;
  localparam int IdleLimit = 20000;

  typedef struct {
    cbcr_pkg::coord_t left, top, right, bottom, ctr_x, ctr_y;
    logic [cbcr_pkg::RadW-1:0] radius;
    cbcr_pkg::coord_t px, py, vx, vy;
  } pair_t;

  typedef struct {
    logic hit;
    cbcr_pkg::coord_t px, py, vx, vy;
  } response_t;

  // Directed row: the pair and, where known at a glance, its response.
  typedef struct {
    pair_t pair;
    logic known;
    response_t resp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cbcr_pkg::coord_t box_left_i = '0, box_top_i = '0, box_right_i = '0, box_bottom_i = '0;
  cbcr_pkg::coord_t center_x_i = '0, center_y_i = '0;
  logic [cbcr_pkg::RadW-1:0] circle_radius_i = '0;
  cbcr_pkg::coord_t pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  cbcr_pkg::coord_t new_pos_x_o, new_pos_y_o, new_vel_x_o, new_vel_y_o;

  response_t pending_resp[$];
  row_t directed[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int next_gap = 0;
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;

  always #10 clk_i = ~clk_i;

  circle_box_collision_resolve dut (.*);

  // Rounded shift, half away from zero.
  function automatic longint round_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint nearest(longint c, longint lo, longint hi);
    longint t;
    t = (c < hi) ? c : hi;
    return (lo > t) ? lo : t;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v) r = r + (64'sd1 <<< b);
    end
    return r;
  endfunction

  // Unit normal component at the normal format, rounded half away from zero.
  function automatic longint normal_part(longint num, longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = ((m <<< NormFrac) + den / 2) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic response_t resolve(pair_t p);
    response_t r;
    longint dx, dy, d2, rad, d, ov, nx, ny, dq;
    r = '{1'b0, p.px, p.py, p.vx, p.vy};
    dx = longint'(p.ctr_x) - nearest(p.ctr_x, p.left, p.right);
    dy = longint'(p.ctr_y) - nearest(p.ctr_y, p.top, p.bottom);
    d2 = dx * dx + dy * dy;
    rad = longint'(p.radius);
    if (d2 < rad * rad) begin
      d = floor_sqrt(d2);
      ov = rad - d;
      if (d > 0) begin
        nx = normal_part(dx, d);
        ny = normal_part(dy, d);
      end else begin
        nx = 0;
        ny = -(64'sd1 <<< NormFrac);
      end
      dq = round_shift(longint'(p.vx) * nx + longint'(p.vy) * ny, NormFrac);
      r.hit = 1'b1;
      r.px = cbcr_pkg::coord_t'(clip(longint'(p.px) + round_shift(nx * ov, NormFrac)));
      r.py = cbcr_pkg::coord_t'(clip(longint'(p.py) + round_shift(ny * ov, NormFrac)));
      r.vx = cbcr_pkg::coord_t'(clip(longint'(p.vx) - round_shift(dq * nx, NormFrac)));
      r.vy = cbcr_pkg::coord_t'(clip(longint'(p.vy) - round_shift(dq * ny, NormFrac)));
    end
    return r;
  endfunction

  function automatic cbcr_pkg::coord_t any_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return -24'sh800000;
      default: return cbcr_pkg::coord_t'($urandom);
    endcase
  endfunction

  // Mostly near misses and overlaps around a random box, some pure noise.
  function automatic pair_t random_pair();
    pair_t p;
    int w, h;
    if ($urandom_range(0, 9) == 0) begin
      p = '{any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
            any_coord(), cbcr_pkg::RadW'($urandom), any_coord(), any_coord(),
            any_coord(), any_coord()};
      return p;
    end
    w = $urandom_range(0, 40000);
    h = $urandom_range(0, 40000);
    p.left = cbcr_pkg::coord_t'($signed($urandom_range(0, 16000000)) - 8000000);
    p.top = cbcr_pkg::coord_t'($signed($urandom_range(0, 16000000)) - 8000000);
    p.right = p.left + cbcr_pkg::coord_t'(w);
    p.bottom = p.top + cbcr_pkg::coord_t'(h);
    p.radius = cbcr_pkg::RadW'($urandom_range(0, 65535));
    p.ctr_x = p.left
              + cbcr_pkg::coord_t'($signed($urandom_range(0, w + 140000)) - 70000);
    p.ctr_y = p.top
              + cbcr_pkg::coord_t'($signed($urandom_range(0, h + 140000)) - 70000);
    p.px = ($urandom_range(0, 3) == 0) ? any_coord() : p.ctr_x;
    p.py = ($urandom_range(0, 3) == 0) ? any_coord() : p.ctr_y;
    p.vx = any_coord();
    p.vy = any_coord();
    return p;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // Offer one transaction; the gap before the next one is chosen at acceptance
  // so that valid drops only when a gap really follows.
  task automatic offer(pair_t p);
    repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    box_left_i <= p.left;
    box_top_i <= p.top;
    box_right_i <= p.right;
    box_bottom_i <= p.bottom;
    center_x_i <= p.ctr_x;
    center_y_i <= p.ctr_y;
    circle_radius_i <= p.radius;
    pos_x_i <= p.px;
    pos_y_i <= p.py;
    vel_x_i <= p.vx;
    vel_y_i <= p.vy;
    do @(posedge clk_i); while (!in_ready_o);
    next_gap = gap_len();
    if (next_gap != 0) in_valid_i <= 1'b0;
  endtask

  task automatic add_row(pair_t p, logic known, response_t r);
    directed.push_back('{p, known, r});
  endtask

  // Stimulus: directed table, then random pairs.
  initial begin
    pair_t p, q;
    response_t e;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Clear miss: values pass through.
    p = '{0, 0, 256, 256, 5000, 5000, 256, 11, -22, 33, -44};
    add_row(p, 1'b1, '{1'b0, 11, -22, 33, -44});
    // Zero radius with the center inside: never a hit.
    p = '{0, 0, 256, 256, 128, 128, 0, 1, 2, 3, 4};
    add_row(p, 1'b1, '{1'b0, 1, 2, 3, 4});
    // Center inside the box: normal points up, push by the whole radius.
    p = '{0, 0, 256, 256, 128, 128, 100, 0, 0, 50, 70};
    add_row(p, 1'b1, '{1'b1, 0, -100, 50, 0});
    // Exactly touching is not a hit.
    p = '{0, 0, 256, 256, 356, 128, 100, 7, 7, 7, 7};
    add_row(p, 1'b1, '{1'b0, 7, 7, 7, 7});
    // Overlap from the right, left, top and bottom, and at a corner.
    p = '{0, 0, 256, 256, 300, 128, 100, 300, 128, -500, 9};
    add_row(p, 1'b0, e);
    p = '{0, 0, 256, 256, -30, 128, 100, -30, 128, 500, -9};
    add_row(p, 1'b0, e);
    p = '{0, 0, 256, 256, 100, -40, 90, 100, -40, 3, 900};
    add_row(p, 1'b0, e);
    p = '{0, 0, 256, 256, 100, 290, 90, 100, 290, 3, -900};
    add_row(p, 1'b0, e);
    p = '{0, 0, 256, 256, 290, 290, 200, 290, 290, -400, -300};
    add_row(p, 1'b0, e);
    // Inverted box.
    p = '{256, 256, 0, 0, 128, 128, 300, 0, 0, 10, 10};
    add_row(p, 1'b0, e);
    // Saturation at both ends of the range.
    p = '{0, 0, 256, 256, 128, 128, 65535, 0, -24'sh800000, 0, 0};
    add_row(p, 1'b1, '{1'b1, 0, -24'sh800000, 0, 0});
    p = '{0, 0, 256, 256, 300, 128, 65535, 24'sh7fffff, 0,
          -24'sh800000, 24'sh7fffff};
    add_row(p, 1'b0, e);
    p = '{-24'sh800000, -24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff,
          -24'sh800000, 65535, 24'sh7fffff, -24'sh800000, 24'sh7fffff,
          -24'sh800000};
    add_row(p, 1'b0, e);
    p = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, -24'sh800000,
          -24'sh800000, 65535, -1, -1, -1, -1};
    add_row(p, 1'b0, e);
    foreach (directed[i]) begin
      e = directed[i].known ? directed[i].resp : resolve(directed[i].pair);
      pending_resp.push_back(e);
      offer(directed[i].pair);
    end
    // Random part; a long receiver hold-off runs in the middle.
    for (int i = 0; i < RandomPairs; i++) begin
      if (i == RandomPairs / 2) long_hold = 1'b1;
      q = random_pair();
      pending_resp.push_back(resolve(q));
      offer(q);
    end
    if (next_gap == 0) in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, and one long hold-off while the sender pushes.
  initial begin
    int g;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (Latency * 3) @(posedge clk_i);
      end
      g = gap_len();
      out_ready_i <= (g == 0);
      repeat ((g == 0) ? 1 : g) @(posedge clk_i);
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = pending_resp.pop_front();
        if (hit_o !== want.hit || new_pos_x_o !== want.px || new_pos_y_o !== want.py
            || new_vel_x_o !== want.vx || new_vel_y_o !== want.vy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0b %0d %0d %0d %0d, got %0b %0d %0d %0d %0d",
                     want.hit, want.px, want.py, want.vx, want.vy, hit_o,
                     new_pos_x_o, new_pos_y_o, new_vel_x_o, new_vel_y_o);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // End of run: drain, then keep watching for stray results.
  initial begin
    wait (stim_done);
    wait (pending_resp.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cbcr_pkg.sv
src/circle_box_collision_resolve.sv
src/cbcr_checker.sv
test/circle_box_collision_resolve_tb.sv
